### design/cdpff_pkg.sv
// Shared types, constants and byte-select functions for the CDP frame filter.
package cdpff_pkg;

    localparam int ADDR_BYTES = 6;
    localparam int LEN_END    = 14;
    localparam int HDR_END    = 22;
    localparam int PAY_W      = 9;
    localparam int COUNT_MAX  = 511;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [47:0] MATCH_ADDRESS_RESET = 48'h0100_0CCC_CCCC;
    localparam logic [63:0] LLC_HEADER_RESET    = 64'hAAAA_0300_000C_2000;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_FOR_US  = 2'd1,
        ST_INCOMPLETE  = 2'd2,
        ST_UNKNOWN_LLC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_MATCH_ADDRESS = 2'd0,
        REG_LLC_HEADER    = 2'd1
    } reg_index_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        status_t          status;
        logic [47:0]      source_address;
        logic [PAY_W-1:0] payload_count;
        logic             end_of_run;
    } result_t;

    // one entry per accepted byte that produces anything
    typedef struct packed {
        logic             has_payload;
        logic [7:0]       data_byte;
        logic             has_verdict;
        status_t          status;
        logic [47:0]      source_address;
        logic [PAY_W-1:0] payload_count;
    } cmd_t;

    // byte i of the address, byte 0 most significant
    function automatic logic [7:0] addr_byte(logic [47:0] addr, logic [2:0] i);
        logic [47:0] sh;
        sh = addr >> {3'd5 - i, 3'b000};
        return sh[7:0];
    endfunction

    // byte i of the LLC/SNAP header, byte 0 most significant
    function automatic logic [7:0] llc_byte(logic [63:0] hdr, logic [2:0] i);
        logic [63:0] sh;
        sh = hdr >> {3'd7 - i, 3'b000};
        return sh[7:0];
    endfunction

endpackage

### design/cdpff_front.sv
// Front end: byte position tracking, header compares and verdict classification.
module cdpff_front #(
    parameter int MAX_FRAME = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cdpff_pkg::frame_t   frame,
    input  logic [47:0]         match_address,
    input  logic [63:0]         llc_header,
    input  logic                q_full,
    output logic                q_push,
    output cdpff_pkg::cmd_t     q_cmd
);

    localparam int PosW = $clog2(MAX_FRAME + 1);

    logic [PosW-1:0] pos_reg, pos_next;
    logic            addr_ok_reg, addr_ok_next;
    logic            hdr_ok_reg, hdr_ok_next;
    logic [47:0]     src_reg, src_next;
    logic [15:0]     len_reg, len_next;

    logic            accept;
    logic            in_range;
    logic            payload;
    logic [15:0]     cnt16;
    logic [15:0]     pay_wide;
    logic [cdpff_pkg::PAY_W-1:0] pay;
    cdpff_pkg::status_t status;

    always_comb
    begin
        accept       = push && !q_full;
        in_range     = pos_reg < PosW'(MAX_FRAME);
        pos_next     = pos_reg;
        addr_ok_next = addr_ok_reg;
        hdr_ok_next  = hdr_ok_reg;
        src_next     = src_reg;
        len_next     = len_reg;
        payload      = 1'b0;

        if (in_range)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg < PosW'(cdpff_pkg::ADDR_BYTES))
            begin
                if (frame.frame_byte != cdpff_pkg::addr_byte(match_address, pos_reg[2:0]))
                    addr_ok_next = 1'b0;
            end
            else if (pos_reg < PosW'(2 * cdpff_pkg::ADDR_BYTES))
            begin
                src_next = {src_reg[39:0], frame.frame_byte};
            end
            else if (pos_reg < PosW'(cdpff_pkg::LEN_END))
            begin
                len_next = {len_reg[7:0], frame.frame_byte};
            end
            else if (pos_reg < PosW'(cdpff_pkg::HDR_END))
            begin
                // position 14 maps to header byte 0 modulo 8
                if (frame.frame_byte !=
                    cdpff_pkg::llc_byte(llc_header, pos_reg[2:0] - 3'd6))
                    hdr_ok_next = 1'b0;
            end
            else
            begin
                payload = addr_ok_reg && hdr_ok_reg;
            end
        end

        cnt16    = 16'(pos_next);
        pay_wide = (cnt16 > 16'(cdpff_pkg::HDR_END)) ?
                   cnt16 - 16'(cdpff_pkg::HDR_END) : 16'd0;
        pay      = (pay_wide > 16'(cdpff_pkg::COUNT_MAX)) ?
                   cdpff_pkg::PAY_W'(cdpff_pkg::COUNT_MAX) : pay_wide[cdpff_pkg::PAY_W-1:0];

        if (!addr_ok_next)
            status = cdpff_pkg::ST_NOT_FOR_US;
        else if (cnt16 < 16'(cdpff_pkg::HDR_END))
            status = cdpff_pkg::ST_INCOMPLETE;
        else if (len_next != cnt16 - 16'(cdpff_pkg::LEN_END))
            status = cdpff_pkg::ST_INCOMPLETE;
        else if (!hdr_ok_next)
            status = cdpff_pkg::ST_UNKNOWN_LLC;
        else
            status = cdpff_pkg::ST_OK;

        q_cmd.has_payload    = payload;
        q_cmd.data_byte      = frame.frame_byte;
        q_cmd.has_verdict    = frame.last_byte;
        q_cmd.status         = status;
        q_cmd.source_address = src_next;
        q_cmd.payload_count  = pay;
        q_push               = accept && (payload || frame.last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            addr_ok_reg <= 1'b1;
            hdr_ok_reg  <= 1'b1;
            src_reg     <= '0;
            len_reg     <= '0;
        end
        else if (accept)
        begin
            if (frame.last_byte)
            begin
                pos_reg     <= '0;
                addr_ok_reg <= 1'b1;
                hdr_ok_reg  <= 1'b1;
                src_reg     <= '0;
                len_reg     <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                addr_ok_reg <= addr_ok_next;
                hdr_ok_reg  <= hdr_ok_next;
                src_reg     <= src_next;
                len_reg     <= len_next;
            end
        end
    end

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PosW'(MAX_FRAME))
        else $error("byte position beyond frame limit");

endmodule

### design/cdpff_queue.sv
// Short command queue between the front end and the result sequencer.
module cdpff_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cdpff_pkg::cmd_t din,
    output logic            full,
    input  logic            pop,
    output cdpff_pkg::cmd_t dout,
    output logic            empty
);

    cdpff_pkg::cmd_t                    entry_reg [cdpff_pkg::QUEUE_DEPTH];
    logic [cdpff_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [cdpff_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                               do_push, do_pop;

    always_comb
    begin
        full    = count_reg == cdpff_pkg::QCNT_W'(cdpff_pkg::QUEUE_DEPTH);
        empty   = count_reg == '0;
        do_push = push && !full;
        do_pop  = pop && !empty;
        dout    = entry_reg[rd_ptr_reg];
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= din;
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cdpff_pkg::QCNT_W'(cdpff_pkg::QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

endmodule

### design/cdpff_back.sv
// Back end: expands queued commands into payload and verdict results.
module cdpff_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  cdpff_pkg::cmd_t      q_head,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output cdpff_pkg::result_t   result
);

    cdpff_pkg::cmd_t    cur_reg, cur_next;
    logic               cur_valid_reg, cur_valid_next;
    cdpff_pkg::result_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    cdpff_pkg::cmd_t    src, rest;
    logic               src_valid, rest_valid, load;
    cdpff_pkg::result_t res;

    always_comb
    begin
        src       = cur_valid_reg ? cur_reg : q_head;
        src_valid = cur_valid_reg || !q_empty;
        load      = src_valid && (!out_valid_reg || pop);
        rest      = src;
        res       = '0;

        if (src.has_payload)
        begin
            res.kind         = 1'b0;
            res.data_byte    = src.data_byte;
            res.status       = cdpff_pkg::ST_OK;
            res.end_of_run   = !src.has_verdict;
            rest.has_payload = 1'b0;
            rest_valid       = src.has_verdict;
        end
        else
        begin
            res.kind           = 1'b1;
            res.status         = src.status;
            res.source_address = src.source_address;
            res.payload_count  = src.payload_count;
            res.end_of_run     = 1'b1;
            rest_valid         = 1'b0;
        end

        q_pop          = load && !cur_valid_reg;
        cur_next       = load ? rest : cur_reg;
        cur_valid_next = load ? rest_valid : cur_valid_reg;
        out_next       = load ? res : out_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        empty  = !out_valid_reg;
        result = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    a_held_is_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.has_verdict && !cur_reg.has_payload))
        else $error("held command is not a lone verdict");

    a_verdict_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind) |-> out_reg.end_of_run)
        else $error("verdict without end of run");

    a_split_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !res.end_of_run) |=> cur_valid_reg)
        else $error("payload marked mid-run with no verdict pending");

endmodule

### design/cdp_frame_filter_unit.sv
// Top level of the CDP frame filter: config registers, front end, queue and back end.
// Path: a result passes the command queue and the output register to the result ports;
// a verdict after a payload result on the same byte is held until that payload is taken.
// Throughput: one byte per cycle unless the queue is full; a byte with payload and verdict
// gives two results, absorbed by the four-entry command queue while the output port drains.
// Reset: asynchronous, active low; clears frame state, queue and output, and loads
// the default destination address and LLC/SNAP header.
module cdp_frame_filter_unit #(
    parameter int MAX_FRAME = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  cdpff_pkg::frame_t    frame,
    output logic                 empty,
    input  logic                 pop,
    output cdpff_pkg::result_t   result,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data
);

    logic [47:0]     match_address_reg;
    logic [63:0]     llc_header_reg;

    logic            q_push, q_pop, q_full, q_empty;
    cdpff_pkg::cmd_t q_cmd, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_address_reg <= cdpff_pkg::MATCH_ADDRESS_RESET;
            llc_header_reg    <= cdpff_pkg::LLC_HEADER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cdpff_pkg::REG_MATCH_ADDRESS: match_address_reg <= cfg_data[47:0];
                cdpff_pkg::REG_LLC_HEADER:    llc_header_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign full = q_full;

    cdpff_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .frame         (frame),
        .match_address (match_address_reg),
        .llc_header    (llc_header_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    cdpff_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty)
    );

    cdpff_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

### tb/frame_filter_checker.sv
// Checker for the CDP frame filter: predicts payload and verdict transactions and compares them.
module frame_filter_checker #(
    parameter int MAX_FRAME = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  cdpff_pkg::frame_t   frame,
    input  logic                empty,
    input  logic                pop,
    input  cdpff_pkg::result_t  result,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output int unsigned         mismatch_count,
    output int unsigned         results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [47:0] dest_address;
    logic [63:0] snap_header;

    int unsigned byte_pos;
    logic        dest_ok;
    logic        snap_ok;
    logic [47:0] src_capture;
    logic [15:0] length_seen;

    cdpff_pkg::result_t outputs_due[$];

    task automatic clear_frame_state();
        byte_pos    = 0;
        dest_ok     = 1'b1;
        snap_ok     = 1'b1;
        src_capture = '0;
        length_seen = '0;
    endtask

    // one accepted byte: header compares, payload forwarding, verdict on the last byte
    task automatic filter_byte(input cdpff_pkg::frame_t f);
        cdpff_pkg::result_t r;
        int unsigned p;
        int unsigned cnt;
        int unsigned extra;
        int unsigned first_new;
        logic [7:0]  want;
        first_new = outputs_due.size();
        if (byte_pos < MAX_FRAME) begin
            p = byte_pos;
            if (p < cdpff_pkg::ADDR_BYTES) begin
                want = dest_address[8*(5-p) +: 8];
                if (f.frame_byte != want)
                    dest_ok = 1'b0;
            end
            else if (p < 2*cdpff_pkg::ADDR_BYTES)
                src_capture = {src_capture[39:0], f.frame_byte};
            else if (p < cdpff_pkg::LEN_END)
                length_seen = {length_seen[7:0], f.frame_byte};
            else if (p < cdpff_pkg::HDR_END) begin
                want = snap_header[8*(21-p) +: 8];
                if (f.frame_byte != want)
                    snap_ok = 1'b0;
            end
            else if (dest_ok && snap_ok) begin
                r           = '0;
                r.kind      = 1'b0;
                r.data_byte = f.frame_byte;
                r.status    = cdpff_pkg::ST_OK;
                outputs_due.push_back(r);
            end
            byte_pos = p + 1;
        end
        if (f.last_byte) begin
            cnt   = byte_pos;
            extra = (cnt > cdpff_pkg::HDR_END) ? cnt - cdpff_pkg::HDR_END : 0;
            if (extra > cdpff_pkg::COUNT_MAX)
                extra = cdpff_pkg::COUNT_MAX;
            r      = '0;
            r.kind = 1'b1;
            if (!dest_ok)
                r.status = cdpff_pkg::ST_NOT_FOR_US;
            else if (cnt < cdpff_pkg::HDR_END)
                r.status = cdpff_pkg::ST_INCOMPLETE;
            else if (length_seen != cnt - cdpff_pkg::LEN_END)
                r.status = cdpff_pkg::ST_INCOMPLETE;
            else if (!snap_ok)
                r.status = cdpff_pkg::ST_UNKNOWN_LLC;
            else
                r.status = cdpff_pkg::ST_OK;
            r.source_address = src_capture;
            r.payload_count  = extra[cdpff_pkg::PAY_W-1:0];
            outputs_due.push_back(r);
            clear_frame_state();
        end
        if (outputs_due.size() > first_new)
            outputs_due[outputs_due.size()-1].end_of_run = 1'b1;
    endtask

    function automatic int unsigned field_differs(string name, logic [63:0] want,
                                                  logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cdpff_pkg::result_t want;
        if (!rst_n) begin
            dest_address = cdpff_pkg::MATCH_ADDRESS_RESET;
            snap_header  = cdpff_pkg::LLC_HEADER_RESET;
            clear_frame_state();
            outputs_due.delete();
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    cdpff_pkg::REG_MATCH_ADDRESS: dest_address = cfg_data[47:0];
                    cdpff_pkg::REG_LLC_HEADER:    snap_header  = cfg_data;
                    default:                      ;
                endcase
            end
            if (push && !full)
                filter_byte(frame);
            if (pop && !empty) begin
                if (outputs_due.size() == 0) begin
                    $error("unexpected result transaction: kind %0b status %0d",
                           result.kind, result.status);
                    mismatch_count++;
                end
                else begin
                    want = outputs_due.pop_front();
                    mismatch_count += field_differs("kind", want.kind, result.kind);
                    mismatch_count += field_differs("data_byte", want.data_byte,
                                                    result.data_byte);
                    mismatch_count += field_differs("status", want.status, result.status);
                    mismatch_count += field_differs("source_address", want.source_address,
                                                    result.source_address);
                    mismatch_count += field_differs("payload_count", want.payload_count,
                                                    result.payload_count);
                    mismatch_count += field_differs("end_of_run", want.end_of_run,
                                                    result.end_of_run);
                end
            end
        end
        results_due = outputs_due.size();
    end

endmodule

### tb/tb_top.sv
// Testbench top for the CDP frame filter: clock, reset, frame stimulus, config phases, verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FRAME    = 512;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 20;
    localparam int PHASES       = 8;

    // indexes past the two registers; writes there must have no effect
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    typedef enum {
        FR_GOOD,
        FR_BAD_DEST,
        FR_BAD_LENGTH,
        FR_BAD_LLC,
        FR_SHORT,
        FR_NOISE
    } frame_shape_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    cdpff_pkg::frame_t  frame;
    logic               empty;
    logic               pop;
    cdpff_pkg::result_t result;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    int unsigned mismatch_count;
    int unsigned results_due;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned bytes_sent;
    int unsigned quiet_cycles;
    bit          want_hold;

    logic [47:0] cur_addr;
    logic [63:0] cur_llc;

    cdp_frame_filter_unit #(
        .MAX_FRAME(MAX_FRAME)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .frame     (frame),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_filter_checker #(
        .MAX_FRAME(MAX_FRAME)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .frame          (frame),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (want_hold && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    pop <= 1'b0;
                    @(posedge clk);
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        frame <= {b, last};
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_shape_t shape, input int unsigned total);
        logic [7:0]  bytes[$];
        logic [47:0] src;
        logic [15:0] len_word;
        int unsigned taken;
        int unsigned span;
        int unsigned k;
        src      = 48'({$urandom(), $urandom()});
        taken    = (total > MAX_FRAME) ? MAX_FRAME : total;
        len_word = 16'(taken - cdpff_pkg::LEN_END);
        if (shape == FR_BAD_LENGTH)
            len_word = len_word + 16'($urandom_range(1, 65535));
        span = (total > cdpff_pkg::HDR_END) ? total : cdpff_pkg::HDR_END;
        for (k = 0; k < span; k++)
        begin
            if (shape == FR_NOISE || k >= cdpff_pkg::HDR_END)
                bytes.push_back(8'($urandom_range(255)));
            else if (k < cdpff_pkg::ADDR_BYTES)
                bytes.push_back(cur_addr[8*(5-k) +: 8]);
            else if (k < 2*cdpff_pkg::ADDR_BYTES)
                bytes.push_back(src[8*(11-k) +: 8]);
            else if (k < cdpff_pkg::LEN_END)
                bytes.push_back(len_word[8*(13-k) +: 8]);
            else
                bytes.push_back(cur_llc[8*(21-k) +: 8]);
        end
        if (shape == FR_BAD_DEST) begin
            k = $urandom_range(0, (total < cdpff_pkg::ADDR_BYTES) ?
                                  total - 1 : cdpff_pkg::ADDR_BYTES - 1);
            bytes[k] = bytes[k] ^ 8'($urandom_range(1, 255));
        end
        if (shape == FR_BAD_LLC) begin
            k = cdpff_pkg::LEN_END + $urandom_range(0, 7);
            bytes[k] = bytes[k] ^ 8'($urandom_range(1, 255));
        end
        for (k = 0; k < total; k++)
            send_byte(bytes[k], k == total - 1);
    endtask

    task automatic random_frame();
        int unsigned roll;
        int unsigned total;
        roll = $urandom_range(99);
        if ($urandom_range(59) == 0)
            total = cdpff_pkg::HDR_END + $urandom_range(100, MAX_FRAME);
        else
            total = cdpff_pkg::HDR_END + $urandom_range(0, 30);
        if (roll < 70)
            send_frame(FR_GOOD, total);
        else if (roll < 78)
            send_frame(FR_BAD_DEST, $urandom_range(1, 3) == 1 ? $urandom_range(1, 5) : total);
        else if (roll < 85)
            send_frame(FR_BAD_LENGTH, total);
        else if (roll < 92)
            send_frame(FR_BAD_LLC, total);
        else if (roll < 96)
            send_frame(FR_SHORT, $urandom_range(1, cdpff_pkg::HDR_END - 1));
        else
            send_frame(FR_NOISE, $urandom_range(1, 40));
    endtask

    // stop offering and let every pending result drain
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == cdpff_pkg::REG_MATCH_ADDRESS)
            cur_addr = data[47:0];
        else if (idx == cdpff_pkg::REG_LLC_HEADER)
            cur_llc = data;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned phase_start;
        push           = 1'b0;
        frame          = '0;
        cfg_write      = 1'b0;
        cfg_index      = cdpff_pkg::REG_MATCH_ADDRESS;
        cfg_data       = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bytes_sent     = 0;
        want_hold      = 1'b0;
        cur_addr       = cdpff_pkg::MATCH_ADDRESS_RESET;
        cur_llc        = cdpff_pkg::LLC_HEADER_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames with the reset configuration
        send_frame(FR_SHORT, 1);
        send_frame(FR_BAD_DEST, 3);
        send_frame(FR_SHORT, cdpff_pkg::HDR_END - 1);
        send_frame(FR_GOOD, cdpff_pkg::HDR_END);
        send_frame(FR_GOOD, cdpff_pkg::HDR_END + 1);
        send_frame(FR_BAD_LLC, cdpff_pkg::HDR_END + 2);
        send_frame(FR_BAD_LENGTH, cdpff_pkg::HDR_END + 2);
        send_frame(FR_NOISE, 5);
        wait_idle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(cdpff_pkg::REG_MATCH_ADDRESS, '0);
                    write_reg(cdpff_pkg::REG_LLC_HEADER, '0);
                end
                2:
                begin
                    write_reg(cdpff_pkg::REG_MATCH_ADDRESS, '1);
                    write_reg(cdpff_pkg::REG_LLC_HEADER, '1);
                end
                7:
                begin
                    write_reg(cdpff_pkg::REG_MATCH_ADDRESS,
                              {16'hFFFF, cdpff_pkg::MATCH_ADDRESS_RESET});
                    write_reg(cdpff_pkg::REG_LLC_HEADER, cdpff_pkg::LLC_HEADER_RESET);
                end
                default:
                begin
                    if (phase != 0) begin
                        write_reg(cdpff_pkg::REG_MATCH_ADDRESS, {$urandom(), $urandom()});
                        write_reg(cdpff_pkg::REG_LLC_HEADER, {$urandom(), $urandom()});
                    end
                end
            endcase
            if (phase != 0)
                write_reg(phase[0] ? REG_SPARE_LO : REG_SPARE_HI, {$urandom(), $urandom()});

            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase

            phase_start = bytes_sent;
            if (phase == 3) begin
                want_hold = 1'b1;
                send_frame(FR_GOOD, cdpff_pkg::HDR_END + 40);
            end
            if (phase == 5)
                send_frame(FR_GOOD, MAX_FRAME + $urandom_range(1, 4));
            while (bytes_sent - phase_start < PHASE_BYTES)
                random_frame();
            wait_idle();
        end

        if (mismatch_count == 0 && results_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
